@@ rtl/core/ppfl_pkg.sv @@
// Shared types, codes and constants for the physical page free list.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ppfl_pkg;

    // Fixed widths of the request and result fields.
    localparam int DATA_W    = 32;
    localparam int ADDR_BITS = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 16;
    localparam int PADDR_W   = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PAGES        = 32768;
    localparam int DEF_PAGE_OFFSET_BITS = 12;

    // Register reset values.
    localparam logic [DATA_W-1:0] KERNEL_END_RST = 32'h8000_0000;
    localparam logic [DATA_W-1:0] PHYS_TOP_RST   = 32'h8800_0000;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_KERNEL_END = 1'b0;
    localparam logic REG_PHYS_TOP   = 1'b1;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Operands and mode for the shared add/subtract unit.
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              sub;
    } alu_req_t;

endpackage

`default_nettype wire

@@ rtl/core/ppfl_alu.sv @@
// Shared add/subtract unit with an unsigned less-than flag.
// Depends on ppfl_pkg for the operand width and the request struct.
`default_nettype none

module ppfl_alu (
    input  ppfl_pkg::alu_req_t          req,
    output logic [ppfl_pkg::DATA_W-1:0] sum,
    output logic                        lt
);
    import ppfl_pkg::*;

    logic [DATA_W-1:0] b_eff;
    logic [DATA_W:0]   full_sum;

    // Subtraction is a + ~b + 1; a missing carry out means a borrow.
    assign b_eff    = req.sub ? ~req.b : req.b;
    assign full_sum = {1'b0, req.a} + {1'b0, b_eff} + (DATA_W+1)'(req.sub);
    assign sum      = full_sum[DATA_W-1:0];
    assign lt       = req.sub & ~full_sum[DATA_W];

endmodule

`default_nettype wire

@@ rtl/core/ppfl_stack.sv @@
// Page number stack storage: one write port and one registered read port.
// Depends on ppfl_pkg for the defaults of its size parameters.
`default_nettype none

module ppfl_stack #(
    parameter int DEPTH = ppfl_pkg::DEF_MAX_PAGES,
    parameter int WIDTH = ppfl_pkg::ADDR_BITS - ppfl_pkg::DEF_PAGE_OFFSET_BITS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import ppfl_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/physical_page_free_list.sv @@
// Physical page free list: a LIFO pool of free page frames with its sequencer.
// Depends on ppfl_pkg, ppfl_alu and ppfl_stack.
//
// A request is taken when start is high and busy is low; its one result is
// shown for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle. A no-op request (op 3) gives its result
// in the cycle after it is taken. Free keeps busy high through S_FREE_LO and
// S_FREE_HI, alloc through S_ALLOC_RD and S_ALLOC_OUT (only S_ALLOC_RD on an
// empty pool); the result follows in the next cycle. Init keeps busy high
// through S_INIT_BASE and then S_INIT_LOOP, where the pages go one per cycle
// through the single write port of the stack memory while the shared adder
// compares the running page number with the top of the range. The stack memory
// has no clearing pass after reset; only entries below the current count are ever read.
`default_nettype none

module physical_page_free_list #(
    parameter int MAX_PAGES        = ppfl_pkg::DEF_MAX_PAGES,
    parameter int PAGE_OFFSET_BITS = ppfl_pkg::DEF_PAGE_OFFSET_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [ppfl_pkg::OP_W-1:0]       op,
    input  logic [ppfl_pkg::DATA_W-1:0]     page_in_addr,
    // Result channel
    output logic                            done,
    output logic [ppfl_pkg::DATA_W-1:0]     page_out_addr,
    output logic [ppfl_pkg::STATUS_W-1:0]   status,
    output logic [ppfl_pkg::COUNT_W-1:0]    free_count,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppfl_pkg::PADDR_W-1:0]    paddr,
    input  logic [ppfl_pkg::DATA_W-1:0]     pwdata,
    output logic [ppfl_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import ppfl_pkg::*;

    localparam int AW    = $clog2(MAX_PAGES);
    localparam int DW    = $clog2(MAX_PAGES + 1);
    localparam int PN_W  = ADDR_BITS - PAGE_OFFSET_BITS;
    localparam int CUR_W = PN_W + 1;
    localparam logic [DATA_W-1:0] OFF_MASK =
        DATA_W'((64'd1 << PAGE_OFFSET_BITS) - 64'd1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_PAGES);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_FREE_LO   = 7'b0000010,
        S_FREE_HI   = 7'b0000100,
        S_ALLOC_RD  = 7'b0001000,
        S_ALLOC_OUT = 7'b0010000,
        S_INIT_BASE = 7'b0100000,
        S_INIT_LOOP = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [CUR_W-1:0]      cursor_reg, cursor_next;
    logic                  bad_reg, bad_next;
    logic                  done_reg, done_next;
    logic [DATA_W-1:0]     page_out_reg, page_out_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     kernel_end_reg;
    logic [DATA_W-1:0]     phys_top_reg;

    logic                  accept;
    logic                  cfg_wr;
    logic                  pool_full;
    logic                  misaligned;
    logic [DATA_W-1:0]     limit_pn;

    alu_req_t              alu_req;
    logic [DATA_W-1:0]     alu_sum;
    logic                  alu_lt;

    logic                  stk_we;
    logic [AW-1:0]         stk_waddr;
    logic [PN_W-1:0]       stk_wdata;
    logic                  stk_re;
    logic [AW-1:0]         stk_raddr;
    logic [PN_W-1:0]       stk_rdata;

    assign accept     = start & ~busy;
    assign busy       = (state_reg != S_IDLE);
    assign pool_full  = (depth_reg == DEPTH_MAX);
    assign misaligned = |(addr_reg & OFF_MASK);
    assign limit_pn   = DATA_W'(phys_top_reg >> PAGE_OFFSET_BITS);

    // Configuration registers and read-back.
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PHYS_TOP) ? phys_top_reg : kernel_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg <= KERNEL_END_RST;
            phys_top_reg   <= PHYS_TOP_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_KERNEL_END)
            begin
                kernel_end_reg <= pwdata;
            end
            else
            begin
                phys_top_reg <= pwdata;
            end
        end
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req.a   = DATA_W'(0);
        alu_req.b   = DATA_W'(0);
        alu_req.sub = 1'b1;
        case (state_reg)
            S_FREE_LO:
            begin
                alu_req.a = addr_reg;
                alu_req.b = kernel_end_reg;
            end
            S_FREE_HI:
            begin
                alu_req.a = addr_reg;
                alu_req.b = phys_top_reg;
            end
            S_ALLOC_RD:
            begin
                alu_req.a = DATA_W'(depth_reg);
                alu_req.b = DATA_W'(1);
            end
            S_INIT_BASE:
            begin
                // Round the kernel end up to a page number.
                alu_req.a   = DATA_W'(kernel_end_reg >> PAGE_OFFSET_BITS);
                alu_req.b   = DATA_W'(|(kernel_end_reg & OFF_MASK));
                alu_req.sub = 1'b0;
            end
            S_INIT_LOOP:
            begin
                alu_req.a = DATA_W'(cursor_reg);
                alu_req.b = limit_pn;
            end
            default:
            begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    ppfl_alu u_alu (
        .req (alu_req),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        cursor_next   = cursor_reg;
        bad_next      = bad_reg;
        done_next     = 1'b0;
        page_out_next = DATA_W'(0);
        status_next   = ST_OK;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[AW-1:0];
        stk_wdata     = addr_reg[DATA_W-1 -: PN_W];
        stk_re        = 1'b0;
        stk_raddr     = alu_sum[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_FREE:  state_next = S_FREE_LO;
                        OP_ALLOC: state_next = S_ALLOC_RD;
                        OP_INIT:  state_next = S_INIT_BASE;
                        default:
                        begin
                            // Unused code: report the count and do nothing.
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_FREE_LO:
            begin
                bad_next   = misaligned | alu_lt;
                state_next = S_FREE_HI;
            end
            S_FREE_HI:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (bad_reg || !alu_lt)
                begin
                    status_next = ST_INVALID;
                end
                else if (pool_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
            end
            S_ALLOC_RD:
            begin
                if (depth_reg == DW'(0))
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    depth_next = alu_sum[DW-1:0];
                    state_next = S_ALLOC_OUT;
                end
            end
            S_ALLOC_OUT:
            begin
                done_next     = 1'b1;
                page_out_next = DATA_W'({stk_rdata, {PAGE_OFFSET_BITS{1'b0}}});
                state_next    = S_IDLE;
            end
            S_INIT_BASE:
            begin
                cursor_next = alu_sum[CUR_W-1:0];
                depth_next  = DW'(0);
                state_next  = S_INIT_LOOP;
            end
            S_INIT_LOOP:
            begin
                // One page per cycle until the range ends or the pool fills.
                if (!alu_lt)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (pool_full)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    stk_we      = 1'b1;
                    stk_wdata   = cursor_reg[PN_W-1:0];
                    depth_next  = depth_reg + DW'(1);
                    cursor_next = cursor_reg + CUR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ppfl_stack #(
        .DEPTH (MAX_PAGES),
        .WIDTH (PN_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= DW'(0);
            cursor_reg <= CUR_W'(0);
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= page_in_addr;
        end
        bad_reg      <= bad_next;
        page_out_reg <= page_out_next;
        status_reg   <= status_next;
    end

    assign done          = done_reg;
    assign page_out_addr = page_out_reg;
    assign status        = status_reg;
    assign free_count    = COUNT_W'(depth_reg);

    // A result strobe always comes with the sequencer back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while the sequencer is busy");

    // The page count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("page count above capacity");

    // A stack write never lands beyond the last entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> !pool_full)
        else $error("stack write on a full pool");

    // Entering the alloc output step follows a pop of exactly one page.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_OUT) |-> (depth_reg == $past(depth_reg) - DW'(1)))
        else $error("alloc did not pop one page");

    // The unused operation code answers in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op != OP_FREE && op != OP_ALLOC && op != OP_INIT) |=> done_reg)
        else $error("no-op request gave no result");

endmodule

`default_nettype wire

@@ sim/ppfl_checker.sv @@
// Checker for the physical page free list: watches the request, result and register ports.
// Keeps its own model of the page pool and compares every result in order. Uses ppfl_pkg.
`default_nettype none

module ppfl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [ppfl_pkg::OP_W-1:0]       op,
    input  logic [ppfl_pkg::DATA_W-1:0]     page_in_addr,
    input  logic                            done,
    input  logic [ppfl_pkg::DATA_W-1:0]     page_out_addr,
    input  logic [ppfl_pkg::STATUS_W-1:0]   status,
    input  logic [ppfl_pkg::COUNT_W-1:0]    free_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppfl_pkg::PADDR_W-1:0]    paddr,
    input  logic [ppfl_pkg::DATA_W-1:0]     pwdata,
    input  logic [ppfl_pkg::DATA_W-1:0]     prdata,
    input  logic                            pready,
    output int                              mismatch_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppfl_pkg::*;

    localparam int MAX_PAGES    = DEF_MAX_PAGES;
    localparam int PG_BITS      = DEF_PAGE_OFFSET_BITS;
    localparam int PN_W         = ADDR_BITS - PG_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0]   page_addr;
        logic [STATUS_W-1:0] code;
        logic [COUNT_W-1:0]  count;
    } pool_result_t;

    // Model of the pool: stack of page numbers, its depth and the page window.
    logic [PN_W-1:0]   page_stack [MAX_PAGES];
    int unsigned       pool_depth;
    logic [DATA_W-1:0] kernel_end;
    logic [DATA_W-1:0] phys_top;
    pool_result_t      awaited_results [$];
    int                bad_count;

    // Count a failure and report the first few of them.
    task automatic flag_failure(input string msg);
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Apply one request to the pool model and work out the result it gives.
    task automatic predict_pool_op(input logic [OP_W-1:0] code,
                                   input logic [DATA_W-1:0] addr,
                                   output pool_result_t res);
        logic [DATA_W:0] rounded;
        int unsigned     pn;
        int unsigned     limit;
        res = '0;
        res.code = ST_OK;
        case (code)
            OP_FREE:
            begin
                // Address checks win over the full check.
                if (addr[PG_BITS-1:0] != '0 || addr < kernel_end || addr >= phys_top)
                begin
                    res.code = ST_INVALID;
                end
                else if (pool_depth >= MAX_PAGES)
                begin
                    res.code = ST_FULL;
                end
                else
                begin
                    page_stack[pool_depth] = addr[DATA_W-1:PG_BITS];
                    pool_depth++;
                end
            end
            OP_ALLOC:
            begin
                if (pool_depth == 0)
                begin
                    res.code = ST_EMPTY;
                end
                else
                begin
                    pool_depth--;
                    res.page_addr = {page_stack[pool_depth], {PG_BITS{1'b0}}};
                end
            end
            OP_INIT:
            begin
                // Push every whole page from the rounded-up kernel end to the top.
                rounded = {1'b0, kernel_end}
                        + {{(DATA_W + 1 - PG_BITS){1'b0}}, {PG_BITS{1'b1}}};
                pn = 32'(rounded >> PG_BITS);
                limit = phys_top >> PG_BITS;
                pool_depth = 0;
                while (pn < limit)
                begin
                    if (pool_depth >= MAX_PAGES)
                    begin
                        res.code = ST_FULL;
                        break;
                    end
                    page_stack[pool_depth] = PN_W'(pn);
                    pool_depth++;
                    pn++;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(pool_depth);
    endtask

    // Results are compared before new requests are taken in: a result never
    // belongs to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        pool_result_t got;
        pool_result_t fresh;
        logic [DATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            pool_depth = 0;
            kernel_end = KERNEL_END_RST;
            phys_top = PHYS_TOP_RST;
            awaited_results.delete();
            bad_count = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = {page_out_addr, status, free_count};
                if (awaited_results.size() == 0)
                begin
                    flag_failure($sformatf({"result with nothing outstanding: ",
                                            "addr %h status %0d count %0d"},
                                           got.page_addr, got.code, got.count));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        flag_failure($sformatf({"expected addr %h status %0d count %0d, ",
                                                "got addr %h status %0d count %0d"},
                                               want.page_addr, want.code, want.count,
                                               got.page_addr, got.code, got.count));
                    end
                end
            end

            if (start && !busy)
            begin
                predict_pool_op(op, page_in_addr, fresh);
                awaited_results.push_back(fresh);
            end

            // Register port: writes update the window, reads are checked against it.
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[2])
                        REG_KERNEL_END: kernel_end = pwdata;
                        REG_PHYS_TOP:   phys_top = pwdata;
                        default: ;
                    endcase
                end
                else
                begin
                    reg_value = (paddr[2] == REG_PHYS_TOP) ? phys_top : kernel_end;
                    if (prdata !== reg_value)
                    begin
                        flag_failure($sformatf("register read at %0d: expected %h, got %h",
                                               paddr, reg_value, prdata));
                    end
                end
            end

            mismatch_count <= bad_count;
            pending_count <= awaited_results.size();
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_physical_page_free_list.sv @@
// Top of the physical page free list testbench: clock, reset, requests and register writes.
// Depends on ppfl_pkg, the block itself and ppfl_checker, which does all result checking.
`default_nettype none

module tb_physical_page_free_list;
    timeunit 1ns;
    timeprecision 1ps;

    import ppfl_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int PG_BITS     = DEF_PAGE_OFFSET_BITS;
    localparam int PAGE_SZ     = 1 << PG_BITS;
    // A full init is the longest stretch with nothing accepted.
    localparam int STALL_LIMIT = 4 * (DEF_MAX_PAGES + 16);

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = '0;
    logic [DATA_W-1:0]   page_in_addr = '0;
    logic                done;
    logic [DATA_W-1:0]   page_out_addr;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    int                  mismatch_count;
    int                  pending_count;
    int                  stall_cycles = 0;

    // Current page window, used only to aim free requests at legal pages.
    logic [DATA_W-1:0]   window_lo = KERNEL_END_RST;
    logic [DATA_W-1:0]   window_hi = PHYS_TOP_RST;
    bit                  gaps_on = 1'b1;

    always #4 clk = ~clk;

    physical_page_free_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .page_in_addr  (page_in_addr),
        .done          (done),
        .page_out_addr (page_out_addr),
        .status        (status),
        .free_count    (free_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ppfl_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .page_in_addr   (page_in_addr),
        .done           (done),
        .page_out_addr  (page_out_addr),
        .status         (status),
        .free_count     (free_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Watchdog: ends the run when neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Send one request, at times with a random gap in front of it, and wait until it is taken.
    task automatic issue_request(input logic [OP_W-1:0] req_op,
                                 input logic [DATA_W-1:0] req_addr);
        if (gaps_on && $urandom_range(99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        start <= 1'b1;
        op <= req_op;
        page_in_addr <= req_addr;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and wait until every outstanding request has its result.
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // One register transfer: setup, access, then idle with psel low.
    task automatic reg_transfer(input logic is_write, input logic idx,
                                input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram the page window once the block is idle, then read it back.
    task automatic set_window(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        drain_requests();
        reg_transfer(1'b1, REG_KERNEL_END, lo);
        reg_transfer(1'b1, REG_PHYS_TOP, hi);
        reg_transfer(1'b0, REG_KERNEL_END, '0);
        reg_transfer(1'b0, REG_PHYS_TOP, '0);
        window_lo = lo;
        window_hi = hi;
    endtask

    // Mostly legal pages of the window, the rest unaligned or out of range.
    function automatic logic [DATA_W-1:0] pick_free_addr();
        logic [DATA_W:0]   rounded;
        int unsigned       lo_pn;
        int unsigned       hi_pn;
        int unsigned       pick;
        logic [DATA_W-1:0] addr;
        rounded = {1'b0, window_lo} + (PAGE_SZ - 1);
        lo_pn = 32'(rounded >> PG_BITS);
        hi_pn = window_hi >> PG_BITS;
        pick = $urandom_range(9);
        addr = $urandom;
        if (lo_pn < hi_pn && pick < 8)
        begin
            addr = $urandom_range(hi_pn - 1, lo_pn) << PG_BITS;
        end
        case (pick)
            7: addr[PG_BITS-1:0] = PG_BITS'($urandom_range(PAGE_SZ - 1, 1));
            8: addr = {window_hi[DATA_W-1:PG_BITS], {PG_BITS{1'b0}}};
            9: addr = {window_lo[DATA_W-1:PG_BITS], {PG_BITS{1'b0}}} - PAGE_SZ;
            default: ;
        endcase
        return addr;
    endfunction

    // A pool session: init first, then frees and allocs with some noise.
    task automatic random_phase(input int n_items, input bit extra_inits);
        int              roll;
        logic [OP_W-1:0] pick_op;
        issue_request(OP_INIT, $urandom);
        for (int i = 1; i < n_items; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                issue_request(OP_FREE, pick_free_addr());
            end
            else if (roll < 85)
            begin
                issue_request(OP_ALLOC, $urandom);
            end
            else if (roll < 92 && extra_inits)
            begin
                issue_request(OP_INIT, $urandom);
            end
            else if (roll < 95)
            begin
                issue_request(OP_NOP, $urandom);
            end
            else
            begin
                pick_op = OP_W'($urandom_range(3));
                if (pick_op == OP_INIT && !extra_inits)
                begin
                    pick_op = OP_ALLOC;
                end
                issue_request(pick_op, $urandom);
            end
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] swap;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: empty alloc, edges of the window, bad addresses, LIFO order.
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_FREE, 32'h8000_0000);
        issue_request(OP_FREE, 32'h87FF_F000);
        issue_request(OP_FREE, 32'h8800_0000);
        issue_request(OP_FREE, 32'h7FFF_F000);
        issue_request(OP_FREE, 32'h8000_0001);
        issue_request(OP_FREE, 32'hFFFF_FFFF);
        issue_request(OP_FREE, 32'h0000_0000);
        issue_request(OP_NOP, 32'hFFFF_FFFF);
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_ALLOC, 32'h0);

        // Init fills the pool exactly; free on a full pool, bad free on a full pool.
        issue_request(OP_INIT, 32'h0);
        issue_request(OP_FREE, 32'h8000_0000);
        issue_request(OP_FREE, 32'h8000_0001);
        issue_request(OP_ALLOC, 32'h0);

        // Kernel end at zero: page zero is a legal member of the pool.
        set_window(32'h0, 32'h3000);
        issue_request(OP_INIT, 32'h0);
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_ALLOC, 32'h0);
        issue_request(OP_FREE, 32'h0);

        // Inverted range with an unaligned kernel end leaves the pool empty.
        set_window(32'h5001, 32'h1000);
        issue_request(OP_INIT, 32'h0);

        // Widest window: init stops at the capacity.
        set_window(32'h0, 32'hFFFF_FFFF);
        issue_request(OP_INIT, 32'h0);
        issue_request(OP_ALLOC, 32'h0);

        // Highest page of the address space.
        set_window(32'hFFFF_F000, 32'hFFFF_FFFF);
        issue_request(OP_FREE, 32'hFFFF_F000);
        issue_request(OP_ALLOC, 32'h0);

        // Large window: traffic around a full pool.
        set_window(32'h0, 32'h8000_0000 | $urandom);
        random_phase(150, 1'b0);

        // Small random windows, some inverted, the first at the extremes.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
            begin
                lo = 32'hFFFF_FFFF;
                hi = 32'h0;
            end
            else
            begin
                lo = $urandom;
                if ($urandom_range(1) == 0)
                begin
                    lo[PG_BITS-1:0] = '0;
                end
                hi = lo + $urandom_range(40, 0) * PAGE_SZ;
                if ($urandom_range(3) == 0)
                begin
                    hi = hi + $urandom_range(PAGE_SZ - 1);
                end
                if (ph % 4 == 3)
                begin
                    swap = lo;
                    lo = hi;
                    hi = swap;
                end
            end
            set_window(lo, hi);
            gaps_on = !(ph == 4 || ph == 5);
            random_phase(100, 1'b1);
        end

        drain_requests();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/ppfl_pkg.sv
rtl/core/ppfl_alu.sv
rtl/core/ppfl_stack.sv
rtl/core/physical_page_free_list.sv
sim/ppfl_checker.sv
sim/tb_physical_page_free_list.sv
